@@ design/pwm_pkg.sv @@
// ----------------------------------------------------------------------------
// pwm_pkg
// Shared types and constants for the pulse width meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwm_pkg;

    localparam int unsigned TS_W        = 32;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_DATA_W   = 40;   // 33 bits of fields, padded to bytes
    localparam int unsigned OUT_DATA_W  = 104;  // 101 bits of fields, padded to bytes

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_MODE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_LEVEL  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LIMIT = 8'd3;

    // Trigger modes; the remaining codes count as either polarity
    localparam logic [1:0] TRIG_HIGH = 2'd0;
    localparam logic [1:0] TRIG_LOW  = 2'd1;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_t;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_OPEN_HIGH = 3'd1,
        ST_OPEN_LOW  = 3'd2,
        ST_HIGH_DONE = 3'd3,
        ST_LOW_DONE  = 3'd4,
        ST_TIMEOUT   = 3'd5
    } pulse_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] error_count;
        logic [CNT_W-1:0] pulse_count;
        logic             pulse_done;
        logic             width_valid;
        logic [TS_W-1:0]  pulse_width;
        pulse_state_t     pulse_state;
    } result_t;

endpackage : pwm_pkg

`default_nettype wire

@@ design/pulse_width_meter.sv @@
// ----------------------------------------------------------------------------
// pulse_width_meter
// Edge-to-edge pulse width measurement with debounce and timeout.
// ----------------------------------------------------------------------------
// One pin sample with its timestamp is taken per clock and gives exactly one
// result, which appears in the output register on the cycle after the
// transfer. The whole update (edge detect, the width subtracts, the debounce
// and timeout compares and the counters) sits between the sample and the
// output register, so the block sustains one sample per clock; s_tready only
// drops while a finished result waits for m_tready. Configuration writes are
// always taken (cfg_ready is tied high) and should be made while the block is
// idle.
`default_nettype none

module pulse_width_meter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [pwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pwm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample stream
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [pwm_pkg::IN_DATA_W-1:0]    s_tdata,  // pin_level, timestamp[31:0]
    // result stream
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [pwm_pkg::OUT_DATA_W-1:0]   m_tdata   // pulse_state[2:0],
                                                            // pulse_width[31:0],
                                                            // width_valid, pulse_done,
                                                            // pulse_count[31:0],
                                                            // error_count[31:0]
);

    import pwm_pkg::*;

    // configuration
    logic [1:0]        trigger_mode_reg;
    logic              initial_level_reg;
    logic [TS_W-1:0]   timeout_limit_reg;
    logic [TS_W-1:0]   debounce_limit_reg;

    // measurement state
    logic              sample_seen_reg;
    logic              prev_level_reg;
    edge_t             last_edge_kind_reg,  last_edge_kind_next;
    logic [TS_W-1:0]   last_edge_time_reg,  last_edge_time_next;
    pulse_state_t      cur_state_reg,       cur_state_next;
    logic [TS_W-1:0]   width_reg,           width_next;
    logic [CNT_W-1:0]  accepted_count_reg,  accepted_count_next;
    logic [CNT_W-1:0]  timeout_count_reg,   timeout_count_next;
    logic [TS_W-1:0]   timeout_start_reg,   timeout_start_next;

    // result register
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result_next;

    logic              s_accept;
    logic              cfg_accept;
    logic              pin;
    logic [TS_W-1:0]   ts;
    logic              ref_level;
    logic              is_edge;
    edge_t             edge_kind;
    logic              detected;
    logic              done;
    logic [TS_W-1:0]   edge_width;
    logic [TS_W-1:0]   quiet_time;
    logic              timed_out;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !out_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_reg};

    assign pin        = s_tdata[0];
    assign ts         = s_tdata[TS_W:1];
    assign ref_level  = sample_seen_reg ? prev_level_reg : initial_level_reg;
    assign is_edge    = (pin != ref_level);
    assign edge_kind  = pin ? EDGE_RISE : EDGE_FALL;
    assign edge_width = ts - last_edge_time_reg;
    assign quiet_time = ts - timeout_start_reg;
    assign timed_out  = ((cur_state_reg == ST_OPEN_HIGH) || (cur_state_reg == ST_OPEN_LOW))
                        && (timeout_limit_reg != '0) && (quiet_time > timeout_limit_reg);

    // Next state and measurement update for one sample
    always_comb
    begin
        cur_state_next      = cur_state_reg;
        width_next          = width_reg;
        last_edge_kind_next = last_edge_kind_reg;
        last_edge_time_next = last_edge_time_reg;
        accepted_count_next = accepted_count_reg;
        timeout_count_next  = timeout_count_reg;
        timeout_start_next  = timeout_start_reg;
        detected            = 1'b0;
        done                = 1'b0;

        if (is_edge)
        begin
            last_edge_kind_next = edge_kind;
            last_edge_time_next = ts;
            case (trigger_mode_reg)
                TRIG_HIGH:
                begin
                    if (last_edge_kind_reg == EDGE_RISE && edge_kind == EDGE_FALL)
                    begin
                        cur_state_next = ST_HIGH_DONE;
                        detected       = 1'b1;
                    end
                    else if (edge_kind == EDGE_RISE)
                    begin
                        cur_state_next = ST_OPEN_HIGH;
                    end
                    else
                    begin
                        cur_state_next = ST_NONE;
                        width_next     = '0;
                    end
                end
                TRIG_LOW:
                begin
                    if (last_edge_kind_reg == EDGE_FALL && edge_kind == EDGE_RISE)
                    begin
                        cur_state_next = ST_LOW_DONE;
                        detected       = 1'b1;
                    end
                    else if (edge_kind == EDGE_FALL)
                    begin
                        cur_state_next = ST_OPEN_LOW;
                    end
                    else
                    begin
                        cur_state_next = ST_NONE;
                        width_next     = '0;
                    end
                end
                default:
                begin
                    if (last_edge_kind_reg == EDGE_RISE && edge_kind == EDGE_FALL)
                    begin
                        cur_state_next = ST_HIGH_DONE;
                        detected       = 1'b1;
                    end
                    else if (last_edge_kind_reg == EDGE_FALL && edge_kind == EDGE_RISE)
                    begin
                        cur_state_next = ST_LOW_DONE;
                        detected       = 1'b1;
                    end
                    else
                    begin
                        cur_state_next = ST_NONE;
                        width_next     = '0;
                    end
                end
            endcase

            if (detected)
            begin
                // reject bounces, otherwise count the pulse
                if (debounce_limit_reg != '0 && edge_width <= debounce_limit_reg)
                begin
                    cur_state_next = ST_NONE;
                    width_next     = '0;
                end
                else
                begin
                    width_next          = edge_width;
                    accepted_count_next = accepted_count_reg + 1'b1;
                    done                = 1'b1;
                end
                last_edge_kind_next = EDGE_NONE;
                last_edge_time_next = '0;
            end

            if (timeout_limit_reg != '0)
                timeout_start_next = ts;
        end
        else if (timed_out)
        begin
            cur_state_next      = ST_TIMEOUT;
            width_next          = '0;
            timeout_count_next  = timeout_count_reg + 1'b1;
            last_edge_kind_next = EDGE_NONE;
            last_edge_time_next = '0;
        end
    end

    // Result fields taken after the update
    always_comb
    begin
        result_next.pulse_state = cur_state_next;
        if (cur_state_next == ST_OPEN_HIGH || cur_state_next == ST_OPEN_LOW)
            result_next.pulse_width = ts - last_edge_time_next;
        else
            result_next.pulse_width = width_next;
        result_next.width_valid = (cur_state_next != ST_TIMEOUT);
        result_next.pulse_done  = done;
        result_next.pulse_count = accepted_count_next;
        result_next.error_count = timeout_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_mode_reg   <= '0;
            initial_level_reg  <= 1'b0;
            timeout_limit_reg  <= '0;
            debounce_limit_reg <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_TRIGGER_MODE:   trigger_mode_reg   <= cfg_data[1:0];
                REG_INITIAL_LEVEL:  initial_level_reg  <= cfg_data[0];
                REG_TIMEOUT_LIMIT:  timeout_limit_reg  <= cfg_data[TS_W-1:0];
                REG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data[TS_W-1:0];
                default:            ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_seen_reg    <= 1'b0;
            prev_level_reg     <= 1'b0;
            last_edge_kind_reg <= EDGE_NONE;
            last_edge_time_reg <= '0;
            cur_state_reg      <= ST_NONE;
            width_reg          <= '0;
            accepted_count_reg <= '0;
            timeout_count_reg  <= '0;
            timeout_start_reg  <= '0;
        end
        else if (s_accept)
        begin
            sample_seen_reg    <= 1'b1;
            prev_level_reg     <= pin;
            last_edge_kind_reg <= last_edge_kind_next;
            last_edge_time_reg <= last_edge_time_next;
            cur_state_reg      <= cur_state_next;
            width_reg          <= width_next;
            accepted_count_reg <= accepted_count_next;
            timeout_count_reg  <= timeout_count_next;
            timeout_start_reg  <= timeout_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    // payload only moves on a transfer, held while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (s_accept)
            result_reg <= result_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_done_means_completed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.pulse_done |->
            (result_reg.pulse_state == ST_HIGH_DONE || result_reg.pulse_state == ST_LOW_DONE))
        else $error("pulse_done without a completed pulse");

    a_error_only_on_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (timeout_count_next != timeout_count_reg) |->
            (cur_state_next == ST_TIMEOUT))
        else $error("error count moved without a timeout");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (accepted_count_reg == $past(accepted_count_reg)
                      || accepted_count_reg == $past(accepted_count_reg) + 1'b1))
        else $error("pulse count jumped by more than one");

    // an open state left over from an earlier mode may persist until the next edge
    a_either_never_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && trigger_mode_reg[1] && is_edge |->
            !(cur_state_next == ST_OPEN_HIGH || cur_state_next == ST_OPEN_LOW))
        else $error("open state entered in either-polarity mode");

endmodule : pulse_width_meter

`default_nettype wire

@@ tb/pulse_width_meter_test.sv @@
// ----------------------------------------------------------------------------
// pulse_width_meter_test
// Self-checking bench for the pulse width meter: pin samples with timestamps
// go in through the sample stream, each result is checked field by field
// against a cycle-free model of edge detection, debounce and timeout, under
// a series of register settings and with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_meter_test;

    import pwm_pkg::*;

    // Either-polarity codes; the package only names the single-polarity ones
    localparam logic [1:0] TRIG_BOTH  = 2'd2;
    localparam logic [1:0] TRIG_SPARE = 2'd3;

    typedef struct {
        logic             pin;
        logic [TS_W-1:0]  stamp;
    } sample_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;    // pin_level, timestamp[31:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;           // pulse_state[2:0], pulse_width[31:0],
                                               // width_valid, pulse_done,
                                               // pulse_count[31:0], error_count[31:0]

    // Meter model: settings and state
    logic [1:0]       cfg_trigger    = TRIG_HIGH;
    logic             cfg_init_level = 1'b0;
    logic [TS_W-1:0]  cfg_timeout    = '0;
    logic [TS_W-1:0]  cfg_debounce   = '0;
    logic             seen_sample    = 1'b0;
    logic             lvl_prev       = 1'b0;
    edge_t            edge_kind      = EDGE_NONE;
    logic [TS_W-1:0]  edge_stamp     = '0;
    pulse_state_t     meter_state    = ST_NONE;
    logic [TS_W-1:0]  held_width     = '0;
    logic [CNT_W-1:0] accepted_pulses = '0;
    logic [CNT_W-1:0] timeouts        = '0;
    logic [TS_W-1:0]  quiet_since     = '0;
    int               rejected_pulses = 0;

    sample_t pending_q[$];
    result_t expected_q[$];
    sample_t next_sample;
    result_t seen_result;
    result_t want_result;

    int send_idle_pct   = 38;
    int recv_idle_pct   = 38;
    int fail_count      = 0;
    int results_checked = 0;
    int settings_loaded = 0;

    pulse_width_meter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Advance the meter model by one sample and return the result it gives
    function automatic result_t measure_sample(logic pin, logic [TS_W-1:0] stamp);
        logic    ref_lvl;
        edge_t   this_edge;
        logic    closed;
        result_t r;
        ref_lvl      = seen_sample ? lvl_prev : cfg_init_level;
        seen_sample  = 1'b1;
        lvl_prev     = pin;
        closed       = 1'b0;
        r.pulse_done = 1'b0;
        if (pin != ref_lvl)
        begin
            if (pin)
                this_edge = EDGE_RISE;
            else
                this_edge = EDGE_FALL;
            case (cfg_trigger)
                TRIG_HIGH:
                begin
                    if (edge_kind == EDGE_RISE && this_edge == EDGE_FALL)
                    begin
                        meter_state = ST_HIGH_DONE;
                        closed      = 1'b1;
                    end
                    else if (this_edge == EDGE_RISE)
                        meter_state = ST_OPEN_HIGH;
                    else
                    begin
                        meter_state = ST_NONE;
                        held_width  = '0;
                    end
                end
                TRIG_LOW:
                begin
                    if (edge_kind == EDGE_FALL && this_edge == EDGE_RISE)
                    begin
                        meter_state = ST_LOW_DONE;
                        closed      = 1'b1;
                    end
                    else if (this_edge == EDGE_FALL)
                        meter_state = ST_OPEN_LOW;
                    else
                    begin
                        meter_state = ST_NONE;
                        held_width  = '0;
                    end
                end
                default:
                begin
                    if (edge_kind == EDGE_RISE && this_edge == EDGE_FALL)
                    begin
                        meter_state = ST_HIGH_DONE;
                        closed      = 1'b1;
                    end
                    else if (edge_kind == EDGE_FALL && this_edge == EDGE_RISE)
                    begin
                        meter_state = ST_LOW_DONE;
                        closed      = 1'b1;
                    end
                    else
                    begin
                        meter_state = ST_NONE;
                        held_width  = '0;
                    end
                end
            endcase
            if (closed)
            begin
                held_width = stamp - edge_stamp;
                if (cfg_debounce != 0 && held_width <= cfg_debounce)
                begin
                    meter_state = ST_NONE;
                    held_width  = '0;
                    rejected_pulses++;
                end
                else
                begin
                    accepted_pulses++;
                    r.pulse_done = 1'b1;
                end
                edge_kind  = EDGE_NONE;
                edge_stamp = '0;
            end
            else
            begin
                edge_kind  = this_edge;
                edge_stamp = stamp;
            end
            if (cfg_timeout != 0)
                quiet_since = stamp;
        end
        else if ((meter_state == ST_OPEN_HIGH || meter_state == ST_OPEN_LOW) &&
                 cfg_timeout != 0 && stamp - quiet_since > cfg_timeout)
        begin
            meter_state = ST_TIMEOUT;
            held_width  = '0;
            timeouts++;
            edge_kind   = EDGE_NONE;
            edge_stamp  = '0;
        end
        r.pulse_state = meter_state;
        if (meter_state == ST_OPEN_HIGH || meter_state == ST_OPEN_LOW)
            r.pulse_width = stamp - edge_stamp;
        else
            r.pulse_width = held_width;
        r.width_valid = (meter_state != ST_TIMEOUT);
        r.pulse_count = accepted_pulses;
        r.error_count = timeouts;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= 60)
            $display("mismatch at result %0d: %s", results_checked, what);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TRIGGER_MODE:   cfg_trigger    = value[1:0];
            REG_INITIAL_LEVEL:  cfg_init_level = value[0];
            REG_TIMEOUT_LIMIT:  cfg_timeout    = value;
            REG_DEBOUNCE_LIMIT: cfg_debounce   = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [1:0] mode, logic lvl, logic [31:0] tmo,
                                 logic [31:0] deb);
        write_register(REG_TRIGGER_MODE, CFG_DATA_W'(mode));
        write_register(REG_INITIAL_LEVEL, CFG_DATA_W'(lvl));
        write_register(REG_TIMEOUT_LIMIT, tmo);
        write_register(REG_DEBOUNCE_LIMIT, deb);
        settings_loaded++;
    endtask

    task automatic push_sample(logic pin, logic [TS_W-1:0] stamp);
        pending_q.push_back('{pin, stamp});
    endtask

    // Hold until every queued sample is taken and every result has come back
    task automatic wait_for_quiet();
        @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Sample driver: predict on each transfer, then offer the next sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(measure_sample(s_tdata[0], s_tdata[TS_W:1]));
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_sample = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W-TS_W-1){1'b0}}, next_sample.stamp,
                                 next_sample.pin};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_result = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_q.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    want_result = expected_q.pop_front();
                    if (seen_result.pulse_state != want_result.pulse_state)
                        report_mismatch($sformatf("pulse_state got %0d, expected %0d",
                            seen_result.pulse_state, want_result.pulse_state));
                    if (seen_result.pulse_width != want_result.pulse_width)
                        report_mismatch($sformatf("pulse_width got %h, expected %h",
                            seen_result.pulse_width, want_result.pulse_width));
                    if (seen_result.width_valid != want_result.width_valid)
                        report_mismatch($sformatf("width_valid got %b, expected %b",
                            seen_result.width_valid, want_result.width_valid));
                    if (seen_result.pulse_done != want_result.pulse_done)
                        report_mismatch($sformatf("pulse_done got %b, expected %b",
                            seen_result.pulse_done, want_result.pulse_done));
                    if (seen_result.pulse_count != want_result.pulse_count)
                        report_mismatch($sformatf("pulse_count got %0d, expected %0d",
                            seen_result.pulse_count, want_result.pulse_count));
                    if (seen_result.error_count != want_result.error_count)
                        report_mismatch($sformatf("error_count got %0d, expected %0d",
                            seen_result.error_count, want_result.error_count));
                    results_checked++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #200000;
        $display("** pulse_width_meter: FAILED **");
        $finish;
    end

    initial
    begin
        logic [1:0]  trig_codes[4];
        logic [31:0] now;
        logic [31:0] step;
        logic [31:0] tmo;
        logic [31:0] deb;
        logic        pin_lvl;
        int          roll;
        trig_codes = '{TRIG_HIGH, TRIG_LOW, TRIG_BOTH, TRIG_SPARE};
        now        = '0;
        pin_lvl    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // High pulses, first sample an edge against the assumed level, width across wrap
        load_settings(TRIG_HIGH, 1'b1, 32'd0, 32'd0);
        push_sample(1'b0, 32'h0000_0000);
        push_sample(1'b1, 32'h0000_0010);
        push_sample(1'b1, 32'h0000_0015);
        push_sample(1'b0, 32'h0000_0020);
        push_sample(1'b1, 32'hFFFF_FFF0);
        push_sample(1'b0, 32'h0000_0005);
        push_sample(1'b0, 32'hFFFF_FFFF);
        wait_for_quiet();

        // Low pulses: stray rising edge, debounce reject, accept, then a timeout
        load_settings(TRIG_LOW, 1'b0, 32'd10, 32'd3);
        push_sample(1'b0, 32'd100);
        push_sample(1'b1, 32'd101);
        push_sample(1'b0, 32'd110);
        push_sample(1'b1, 32'd113);
        push_sample(1'b0, 32'd200);
        push_sample(1'b1, 32'd204);
        push_sample(1'b0, 32'd300);
        push_sample(1'b0, 32'd305);
        push_sample(1'b0, 32'd311);
        push_sample(1'b0, 32'd312);
        push_sample(1'b1, 32'd320);
        wait_for_quiet();

        // Either polarity: no open state, so no timeout even when quiet
        load_settings(TRIG_BOTH, 1'b0, 32'd5, 32'd0);
        push_sample(1'b0, 32'd400);
        push_sample(1'b1, 32'd410);
        push_sample(1'b0, 32'd420);
        push_sample(1'b1, 32'd425);
        push_sample(1'b1, 32'd500);
        wait_for_quiet();

        // Spare mode code with the widest debounce: every pulse is rejected
        load_settings(TRIG_SPARE, 1'b1, 32'd0, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'd600);
        push_sample(1'b1, 32'd700);
        wait_for_quiet();

        now     = 32'd700;
        pin_lvl = 1'b1;
        for (int k = 0; k < 12; k++)
        begin
            case ($urandom_range(4))
                0:       tmo = 32'd0;
                1:       tmo = 32'd1;
                4:       tmo = $urandom;
                default: tmo = $urandom_range(60, 2);
            endcase
            case ($urandom_range(3))
                0:       deb = 32'd0;
                3:       deb = $urandom;
                default: deb = $urandom_range(20, 1);
            endcase
            if (k == 3)
                tmo = 32'hFFFF_FFFF;
            if (k == 6)
                deb = 32'hFFFF_FFFF;
            load_settings(trig_codes[k % 4], 1'($urandom_range(1)), tmo, deb);
            send_idle_pct = (k == 7 || k == 8) ? 0 : 38;
            recv_idle_pct = send_idle_pct;
            // Steps cluster around the limits so widths land on either side of them
            for (int n = 0; n < 100; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                    step = $urandom_range(4);
                else if (roll < 55)
                    step = cfg_debounce + $urandom_range(4) - 2;
                else if (roll < 75)
                    step = cfg_timeout + $urandom_range(4) - 2;
                else if (roll < 90)
                    step = $urandom_range(64);
                else
                    step = $urandom;
                now = now + step;
                if ($urandom_range(99) < 45)
                    pin_lvl = ~pin_lvl;
                push_sample(pin_lvl, now);
            end
            wait_for_quiet();
        end

        repeat (8) @(negedge clk);
        $display("pulse_width_meter: %0d samples checked under %0d register settings",
                 results_checked, settings_loaded);
        $display("  %0d pulses accepted, %0d rejected by debounce, %0d timeouts",
                 accepted_pulses, rejected_pulses, timeouts);
        if (fail_count == 0)
            $display("** pulse_width_meter: PASSED **");
        else
            $display("** pulse_width_meter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
